// ===== hw/rtl/lvpm_pkg.sv =====
`timescale 1ns / 1ps

package lvpm_pkg;

    // pipeline depth, input register to result register
    localparam int NSTG        = 7;

    localparam int MAX_RB      = 128;
    localparam int GAP2_MIN_RB = 50;
    localparam int PRB_SAT     = 255;

    localparam int VRB_W       = 7;
    localparam int SLOT_W      = 5;
    localparam int PRB_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_DL_RB     = 3'd0,
        CFG_GRP_SIZE    = 3'd1,
        CFG_GAP1_OFFSET = 3'd2,
        CFG_GAP1_ISIZE  = 3'd3,
        CFG_GAP2_OFFSET = 3'd4,
        CFG_GAP2_ISIZE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [VRB_W-1:0]  vrb_index;
        logic [SLOT_W-1:0] slot_number;
        logic              gap_select;
    } t_req;

    typedef struct packed {
        logic [PRB_W-1:0] prb_index;
        logic             valid_res;
    } t_res;

    typedef struct packed {
        logic [NSTG-1:0] load;
        logic [NSTG-1:0] vld;
    } t_pipe_ctrl;

endpackage

// ===== hw/rtl/lvpm_chan_if.sv =====
`timescale 1ns / 1ps

interface lvpm_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lvpm_pipe_ctrl.sv =====
`timescale 1ns / 1ps

module lvpm_pipe_ctrl
    import lvpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output t_pipe_ctrl o_ctrl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] rdy;

    // a stage takes new data when it is empty or the stage after it moves on
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_ctrl.load = rdy;
    assign o_ctrl.vld  = r_vld;

    // input only backs up once every stage holds a transaction
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld && !i_out_ready))
        else $error("input stalled with a free stage");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !(r_vld[NSTG-1] && i_out_ready)) |=>
        ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("accepted transaction not held in pipeline");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_in_valid && o_in_ready) && r_vld[NSTG-1] && i_out_ready) |=>
        ($countones(r_vld) == $past($countones(r_vld)) - 1))
        else $error("delivered transaction not removed");

    a_count_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_in_valid && o_in_ready) == (r_vld[NSTG-1] && i_out_ready)) |=>
        ($countones(r_vld) == $past($countones(r_vld))))
        else $error("in-flight count changed without cause");

endmodule

// ===== hw/rtl/lte_distributed_vrb_to_prb_map_top.sv =====
`timescale 1ns / 1ps

// Distributed VRB to PRB mapper for the LTE downlink. Each request transaction carries a
// VRB index, the slot number (parity only) and the gap choice; the result carries the PRB
// index and a valid flag, which is low, with index 0, for an index at or beyond the RB
// count, gap 2 below 50 RBs, or a zero interleaver or RBG size. One transaction is taken
// per clock while the output is not stalled; a request passes seven register stages, the
// longest of which are the two bit-per-step remainder units (VRB modulo interleaver size,
// and the odd-slot cyclic shift modulo interleaver size).
// Configuration writes take effect at once and must only be made while nothing is in
// flight.

module lte_distributed_vrb_to_prb_map_top
    import lvpm_pkg::*;
#(
    parameter int MAX_RB_CNT = MAX_RB
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lvpm_chan_if.sink             i_req,
    lvpm_chan_if.source           o_res
);

    // restoring remainder step: shift in one dividend bit, subtract if it fits
    function automatic logic [6:0] rem_step(input logic [6:0] r, input logic b,
                                            input logic [6:0] d);
        logic [7:0] s;
        s = {r, b};
        if (s >= {1'b0, d}) begin
            s = s - {1'b0, d};
        end
        return s[6:0];
    endfunction

    // configuration
    logic [6:0] r_n_dl_rb;
    logic [2:0] r_grp_size;
    logic [5:0] r_gap1_offset;
    logic [6:0] r_gap1_isize;
    logic [4:0] r_gap2_offset;
    logic [6:0] r_gap2_isize;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_dl_rb     <= 7'd6;
            r_grp_size    <= 3'd1;
            r_gap1_offset <= 6'd3;
            r_gap1_isize  <= 7'd6;
            r_gap2_offset <= 5'd9;
            r_gap2_isize  <= 7'd18;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_N_DL_RB:     r_n_dl_rb     <= i_cfg_wdata;
                CFG_GRP_SIZE:    r_grp_size    <= i_cfg_wdata[2:0];
                CFG_GAP1_OFFSET: r_gap1_offset <= i_cfg_wdata[5:0];
                CFG_GAP1_ISIZE:  r_gap1_isize  <= i_cfg_wdata;
                CFG_GAP2_OFFSET: r_gap2_offset <= i_cfg_wdata[4:0];
                CFG_GAP2_ISIZE:  r_gap2_isize  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    t_pipe_ctrl pipe;
    logic       in_ready;

    lvpm_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_ctrl      (pipe)
    );

    assign i_req.ready = in_ready;

    // stage 1: select gap set, validity, first remainder steps
    logic       n1_ok;
    logic [6:0] n1_nvrb;
    logic [5:0] n1_ngap;
    logic [6:0] n1_nvrb_m1;
    logic [6:0] n1_rem_n;
    logic [6:0] n1_rem_m;

    logic       r1_ok;
    logic       r1_odd;
    logic [6:0] r1_vrb;
    logic [6:0] r1_nvrb;
    logic [2:0] r1_p;
    logic [5:0] r1_ngap;
    logic [4:0] r1_m1;
    logic [6:0] r1_rem_n;
    logic [2:0] r1_rem_m;

    always_comb begin
        n1_nvrb = i_req.data.gap_select ? r_gap2_isize : r_gap1_isize;
        n1_ngap = i_req.data.gap_select ? {1'b0, r_gap2_offset} : r_gap1_offset;
        n1_ok   = (i_req.data.vrb_index < r_n_dl_rb)
               && ({1'b0, i_req.data.vrb_index} < 8'(MAX_RB_CNT))
               && (n1_nvrb != 7'd0) && (r_grp_size != 3'd0)
               && (!i_req.data.gap_select || (r_n_dl_rb >= 7'(GAP2_MIN_RB)));
        // ceil(Nvrb / 4) - 1, the row count comes from its remainder by P
        n1_nvrb_m1 = n1_nvrb - 7'd1;
        n1_rem_n = '0;
        for (int i = 6; i >= 3; i--) begin
            n1_rem_n = rem_step(n1_rem_n, i_req.data.vrb_index[i], n1_nvrb);
        end
        n1_rem_m = '0;
        for (int i = 4; i >= 2; i--) begin
            n1_rem_m = rem_step(n1_rem_m, n1_nvrb_m1[i+2], {4'b0, r_grp_size});
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[0]) begin
            r1_ok    <= n1_ok;
            r1_odd   <= i_req.data.slot_number[0];
            r1_vrb   <= i_req.data.vrb_index;
            r1_nvrb  <= n1_nvrb;
            r1_p     <= r_grp_size;
            r1_ngap  <= n1_ngap;
            r1_m1    <= n1_nvrb_m1[6:2];
            r1_rem_n <= n1_rem_n;
            r1_rem_m <= n1_rem_m[2:0];
        end
    end

    // stage 2: finish both remainders, row count and block base
    logic [6:0] n2_rem_n;
    logic [6:0] n2_rem_m;
    logic [5:0] n2_nrow;

    logic       r2_ok;
    logic       r2_odd;
    logic [6:0] r2_nvrb;
    logic [5:0] r2_ngap;
    logic [6:0] r2_t;
    logic [6:0] r2_base;
    logic [5:0] r2_nrow;

    always_comb begin
        n2_rem_n = r1_rem_n;
        for (int i = 2; i >= 0; i--) begin
            n2_rem_n = rem_step(n2_rem_n, r1_vrb[i], r1_nvrb);
        end
        n2_rem_m = {4'b0, r1_rem_m};
        for (int i = 1; i >= 0; i--) begin
            n2_rem_m = rem_step(n2_rem_m, r1_m1[i], {4'b0, r1_p});
        end
        // ceil(m / P) * P = (m - 1) - ((m - 1) mod P) + P
        n2_nrow = {1'b0, r1_m1} - {3'b0, n2_rem_m[2:0]} + {3'b0, r1_p};
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[1]) begin
            r2_ok   <= r1_ok;
            r2_odd  <= r1_odd;
            r2_nvrb <= r1_nvrb;
            r2_ngap <= r1_ngap;
            r2_t    <= n2_rem_n;
            r2_base <= r1_vrb - n2_rem_n;
            r2_nrow <= n2_nrow;
        end
    end

    // stage 3: null count, null-region test, both interleaver candidates
    logic [7:0]        n3_nnull;
    logic signed [8:0] n3_thr;
    logic [8:0]        n3_rowmul;

    logic       r3_ok;
    logic       r3_odd;
    logic [6:0] r3_nvrb;
    logic [5:0] r3_ngap;
    logic [6:0] r3_base;
    logic [1:0] r3_tlo;
    logic [5:0] r3_nrow;
    logic [6:0] r3_nn_half;
    logic       r3_nnz;
    logic       r3_sel_null;
    logic [8:0] r3_tw1;
    logic [8:0] r3_tw2;

    always_comb begin
        n3_nnull = {r2_nrow, 2'b00} - {1'b0, r2_nvrb};
        n3_thr   = $signed({2'b0, r2_nvrb}) - $signed({1'b0, n3_nnull});
        unique case (r2_t[1:0])
            2'd0: n3_rowmul = '0;
            2'd1: n3_rowmul = {3'b0, r2_nrow};
            2'd2: n3_rowmul = {2'b0, r2_nrow, 1'b0};
            2'd3: n3_rowmul = {3'b0, r2_nrow} + {2'b0, r2_nrow, 1'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[2]) begin
            r3_ok       <= r2_ok;
            r3_odd      <= r2_odd;
            r3_nvrb     <= r2_nvrb;
            r3_ngap     <= r2_ngap;
            r3_base     <= r2_base;
            r3_tlo      <= r2_t[1:0];
            r3_nrow     <= r2_nrow;
            r3_nn_half  <= n3_nnull[7:1];
            r3_nnz      <= (n3_nnull != 8'd0);
            r3_sel_null <= ($signed({2'b0, r2_t}) >= n3_thr);
            r3_tw1      <= (r2_t[0] ? {2'b0, r2_nrow, 1'b0} : 9'd0)
                         + {3'b0, r2_t[6:1]} + {2'b0, r2_base};
            r3_tw2      <= n3_rowmul + {4'b0, r2_t[6:2]} + {2'b0, r2_base};
        end
    end

    // stage 4: even-slot index, clamp, add half for the odd-slot shift
    logic signed [9:0] n4_ev;
    logic [8:0]        n4_v;

    logic       r4_ok;
    logic       r4_odd;
    logic [6:0] r4_nvrb;
    logic [5:0] r4_ngap;
    logic [6:0] r4_base;
    logic [8:0] r4_v;
    logic [8:0] r4_w;

    always_comb begin
        priority if (r3_nnz && r3_sel_null) begin
            if (r3_tlo[0]) begin
                n4_ev = $signed({1'b0, r3_tw1}) - $signed({4'b0, r3_nrow});
            end else begin
                n4_ev = $signed({1'b0, r3_tw1}) - $signed({4'b0, r3_nrow})
                      + $signed({3'b0, r3_nn_half});
            end
        end else if (r3_nnz && r3_tlo[1]) begin
            n4_ev = $signed({1'b0, r3_tw2}) - $signed({3'b0, r3_nn_half});
        end else begin
            n4_ev = $signed({1'b0, r3_tw2});
        end
        n4_v = n4_ev[9] ? 9'd0 : n4_ev[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[3]) begin
            r4_ok   <= r3_ok;
            r4_odd  <= r3_odd;
            r4_nvrb <= r3_nvrb;
            r4_ngap <= r3_ngap;
            r4_base <= r3_base;
            r4_v    <= n4_v;
            r4_w    <= n4_v + {3'b0, r3_nvrb[6:1]};
        end
    end

    // stage 5: upper remainder steps of the shifted index
    logic [6:0] n5_rem;

    logic       r5_ok;
    logic       r5_odd;
    logic [6:0] r5_nvrb;
    logic [5:0] r5_ngap;
    logic [6:0] r5_base;
    logic [8:0] r5_v;
    logic [3:0] r5_wlo;
    logic [6:0] r5_rem;

    always_comb begin
        n5_rem = '0;
        for (int i = 8; i >= 4; i--) begin
            n5_rem = rem_step(n5_rem, r4_w[i], r4_nvrb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[4]) begin
            r5_ok   <= r4_ok;
            r5_odd  <= r4_odd;
            r5_nvrb <= r4_nvrb;
            r5_ngap <= r4_ngap;
            r5_base <= r4_base;
            r5_v    <= r4_v;
            r5_wlo  <= r4_w[3:0];
            r5_rem  <= n5_rem;
        end
    end

    // stage 6: finish the remainder, pick odd or even slot index
    logic [6:0] n6_rem;

    logic       r6_ok;
    logic [6:0] r6_nvrb;
    logic [5:0] r6_ngap;
    logic [8:0] r6_v2;

    always_comb begin
        n6_rem = r5_rem;
        for (int i = 3; i >= 0; i--) begin
            n6_rem = rem_step(n6_rem, r5_wlo[i], r5_nvrb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[5]) begin
            r6_ok   <= r5_ok;
            r6_nvrb <= r5_nvrb;
            r6_ngap <= r5_ngap;
            r6_v2   <= r5_odd ? ({2'b0, n6_rem} + {2'b0, r5_base}) : r5_v;
        end
    end

    // stage 7: gap correction and saturation
    logic [5:0] n7_half;
    logic [9:0] n7_v3;
    t_res       n7_res;
    t_res       r7_res;

    always_comb begin
        n7_half = r6_nvrb[6:1];
        if (r6_v2 >= {3'b0, n7_half}) begin
            n7_v3 = {1'b0, r6_v2} + {4'b0, r6_ngap} - {4'b0, n7_half};
        end else begin
            n7_v3 = {1'b0, r6_v2};
        end
        n7_res.valid_res = r6_ok;
        if (!r6_ok) begin
            n7_res.prb_index = '0;
        end else if (n7_v3 > 10'(PRB_SAT)) begin
            n7_res.prb_index = PRB_W'(PRB_SAT);
        end else begin
            n7_res.prb_index = n7_v3[PRB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[6]) begin
            r7_res <= n7_res;
        end
    end

    assign o_res.valid = pipe.vld[NSTG-1];
    assign o_res.data  = r7_res;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb
    import lvpm_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 300;
    localparam int SETS_PER_PH  = 8;
    localparam int ITEMS_PER_SET = 33;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] n_dl_rb;
        logic [CFG_DATA_W-1:0] grp_size;
        logic [CFG_DATA_W-1:0] gap1_offset;
        logic [CFG_DATA_W-1:0] gap1_isize;
        logic [CFG_DATA_W-1:0] gap2_offset;
        logic [CFG_DATA_W-1:0] gap2_isize;
    } t_cfg_set;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    lvpm_chan_if #(.T(t_req)) req_if ();
    lvpm_chan_if #(.T(t_res)) res_if ();

    lte_distributed_vrb_to_prb_map_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // shadow copy of the mapping registers, at their own widths
    logic [6:0] sh_n_dl_rb;
    logic [2:0] sh_grp_size;
    logic [5:0] sh_gap1_offset;
    logic [6:0] sh_gap1_isize;
    logic [4:0] sh_gap2_offset;
    logic [6:0] sh_gap2_isize;

    t_res        prb_expected_q[$];
    int unsigned err_cnt      = 0;
    int unsigned res_cnt      = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned stall_left   = 0;
    logic        stall_trig;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_res map_vrb_to_prb(t_req r);
        int   nvrb, ngap, p, n, half, v;
        int   four_p, n_row, n_null, t, base, tw1, tw2;
        logic ok;
        t_res res;
        nvrb = r.gap_select ? int'(sh_gap2_isize) : int'(sh_gap1_isize);
        ngap = r.gap_select ? int'(sh_gap2_offset) : int'(sh_gap1_offset);
        p    = int'(sh_grp_size);
        ok   = (int'(r.vrb_index) < int'(sh_n_dl_rb)) && (int'(r.vrb_index) < MAX_RB) &&
               (nvrb > 0) && (p > 0) &&
               (!r.gap_select || int'(sh_n_dl_rb) >= GAP2_MIN_RB);
        v = 0;
        if (ok) begin
            n      = int'(r.vrb_index);
            half   = nvrb / 2;
            four_p = 4 * p;
            n_row  = ((nvrb + four_p - 1) / four_p) * p;
            n_null = 4 * n_row - nvrb;
            t      = n % nvrb;
            base   = nvrb * (n / nvrb);
            tw1    = 2 * n_row * (t % 2) + t / 2 + base;
            tw2    = n_row * (t % 4) + t / 4 + base;
            v      = tw2;
            // null-region threshold may go negative; compare stays signed
            if (n_null != 0) begin
                if (t >= nvrb - n_null) begin
                    v = ((t % 2) == 0) ? tw1 - n_row + n_null / 2 : tw1 - n_row;
                end else if ((t % 4) >= 2) begin
                    v = tw2 - n_null / 2;
                end
            end
            if (v < 0) v = 0;
            // odd slot: cyclic shift by half the interleaver inside its block
            if (r.slot_number[0]) v = (v + half) % nvrb + base;
            if (v >= half) v = v + ngap - half;
            if (v < 0) v = 0;
            if (v > PRB_SAT) v = PRB_SAT;
        end
        res.prb_index = v[PRB_W-1:0];
        res.valid_res = ok;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        $display("ERROR: result %0d %s: expected %0d, got %0d at %0t",
                 res_cnt, what, exp_v, got_v, $realtime);
        err_cnt++;
    endtask

    // shadow registers, prediction at request acceptance, check at result acceptance
    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got_r;
        if (!i_rst_n) begin
            sh_n_dl_rb     <= 7'd6;
            sh_grp_size    <= 3'd1;
            sh_gap1_offset <= 6'd3;
            sh_gap1_isize  <= 7'd6;
            sh_gap2_offset <= 5'd9;
            sh_gap2_isize  <= 7'd18;
            prb_expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_N_DL_RB:     sh_n_dl_rb     <= i_cfg_wdata[6:0];
                    CFG_GRP_SIZE:    sh_grp_size    <= i_cfg_wdata[2:0];
                    CFG_GAP1_OFFSET: sh_gap1_offset <= i_cfg_wdata[5:0];
                    CFG_GAP1_ISIZE:  sh_gap1_isize  <= i_cfg_wdata[6:0];
                    CFG_GAP2_OFFSET: sh_gap2_offset <= i_cfg_wdata[4:0];
                    CFG_GAP2_ISIZE:  sh_gap2_isize  <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready) begin
                prb_expected_q.push_back(map_vrb_to_prb(req_if.data));
            end
            if (res_if.valid && res_if.ready) begin
                got_r = res_if.data;
                if (prb_expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction, prb_index", 0, got_r.prb_index);
                end else begin
                    exp_r = prb_expected_q.pop_front();
                    if (got_r.prb_index !== exp_r.prb_index)
                        report_mismatch("prb_index", exp_r.prb_index, got_r.prb_index);
                    if (got_r.valid_res !== exp_r.valid_res)
                        report_mismatch("valid_res", exp_r.valid_res, got_r.valid_res);
                end
                res_cnt++;
            end
        end
    end

    // long receiver hold-off, started by a one-cycle trigger
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (stall_trig) begin
            stall_left <= STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= (stall_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, prb_expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_req mk_req(input int vrb, input int slot, input int gap);
        t_req r;
        r.vrb_index   = vrb[VRB_W-1:0];
        r.slot_number = slot[SLOT_W-1:0];
        r.gap_select  = gap[0];
        return r;
    endfunction

    function automatic t_cfg_set mk_cfg(input int n, input int p, input int g1o, input int g1i,
                                        input int g2o, input int g2i);
        t_cfg_set c;
        c.n_dl_rb     = n[6:0];
        c.grp_size    = p[6:0];
        c.gap1_offset = g1o[6:0];
        c.gap1_isize  = g1i[6:0];
        c.gap2_offset = g2o[6:0];
        c.gap2_isize  = g2i[6:0];
        return c;
    endfunction

    // occasionally set the unused upper write-data bits of a narrow register
    function automatic logic [6:0] with_junk(input int value, input int width);
        logic [6:0] junk;
        junk = 7'($urandom()) & ~7'((1 << width) - 1);
        return ($urandom_range(9) == 0) ? (7'(value) | junk) : 7'(value);
    endfunction

    function automatic t_cfg_set rand_cfg();
        int sel, n;
        sel = $urandom_range(99);
        n   = (sel < 60) ? $urandom_range(50, 110) :
              (sel < 85) ? $urandom_range(6, 49) : $urandom_range(0, 127);
        return mk_cfg(n,
            with_junk(($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(0, 7), 3),
            with_junk(($urandom_range(99) < 85) ? $urandom_range(3, 48) : $urandom_range(0, 63), 6),
            ($urandom_range(99) < 85) ? $urandom_range(2, 96) : $urandom_range(0, 127),
            with_junk(($urandom_range(99) < 85) ? $urandom_range(9, 16) : $urandom_range(0, 31), 5),
            ($urandom_range(99) < 85) ? $urandom_range(2, 64) : $urandom_range(0, 127));
    endfunction

    function automatic t_req rand_req();
        int lim;
        lim = int'(sh_n_dl_rb);
        // mostly in-range indices, the rest anywhere in the field
        if (lim > 0 && $urandom_range(99) < 80)
            return mk_req($urandom_range(0, lim - 1), $urandom_range(0, 31), $urandom_range(0, 1));
        return mk_req($urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 1));
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // drain the pipeline, then rewrite all six registers
    task automatic apply_cfg(input t_cfg_set c);
        req_if.valid <= 1'b0;
        // wait on the clock so the last accepted transaction is already queued
        @(posedge i_clk);
        while (prb_expected_q.size() != 0) @(posedge i_clk);
        repeat (NSTG + 2) @(posedge i_clk);
        write_reg(CFG_N_DL_RB,     c.n_dl_rb);
        write_reg(CFG_GRP_SIZE,    c.grp_size);
        write_reg(CFG_GAP1_OFFSET, c.gap1_offset);
        write_reg(CFG_GAP1_ISIZE,  c.gap1_isize);
        write_reg(CFG_GAP2_OFFSET, c.gap2_offset);
        write_reg(CFG_GAP2_ISIZE,  c.gap2_isize);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_req(mk_req(0, 0, 0));
        send_req(mk_req(5, 1, 0));
        send_req(mk_req(6, 0, 0));      // first index beyond the RB count
        send_req(mk_req(5, 0, 1));      // gap 2 in a small cell
        send_req(mk_req(127, 31, 0));
    endtask

    task automatic test_directed_corners();
        apply_cfg(mk_cfg(110, 4, 48, 96, 16, 64));
        send_req(mk_req(0, 0, 0));
        send_req(mk_req(109, 1, 0));
        send_req(mk_req(109, 31, 1));
        send_req(mk_req(110, 0, 1));
        send_req(mk_req(63, 2, 1));
        send_req(mk_req(95, 1, 0));
        // gap 2 either side of the 50 RB threshold
        apply_cfg(mk_cfg(50, 3, 27, 48, 16, 32));
        send_req(mk_req(49, 1, 1));
        send_req(mk_req(20, 0, 1));
        apply_cfg(mk_cfg(49, 3, 27, 48, 16, 32));
        send_req(mk_req(10, 1, 1));
        send_req(mk_req(48, 0, 0));
        // zero RBG size, then zero interleaver size on gap 1 only
        apply_cfg(mk_cfg(110, 0, 48, 96, 16, 64));
        send_req(mk_req(5, 0, 0));
        apply_cfg(mk_cfg(110, 2, 48, 0, 16, 64));
        send_req(mk_req(5, 0, 0));
        send_req(mk_req(5, 0, 1));
        // full-width values: large RBG, odd null count, negative threshold
        apply_cfg(mk_cfg(100, 7, 63, 5, 31, 127));
        send_req(mk_req(4, 1, 0));
        send_req(mk_req(3, 0, 1));
        send_req(mk_req(99, 1, 1));
        apply_cfg(mk_cfg(127, 7, 63, 2, 31, 3));
        send_req(mk_req(126, 1, 0));
        send_req(mk_req(126, 0, 1));
    endtask

    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int s = 0; s < SETS_PER_PH; s++) begin
            apply_cfg(rand_cfg());
            for (int k = 0; k < ITEMS_PER_SET; k++) send_req(rand_req());
        end
    endtask

    task automatic test_backpressure();
        apply_cfg(mk_cfg(110, 3, 41, 96, 16, 64));
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        stall_trig <= 1'b1;
        @(posedge i_clk);
        stall_trig <= 1'b0;
        // sender keeps offering while the receiver holds off, so the input stalls
        for (int k = 0; k < 60; k++) send_req(rand_req());
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_N_DL_RB;
        i_cfg_wdata  <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        stall_trig   <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_corners();
        test_random_traffic(14, 73);
        test_random_traffic(73, 14);
        test_random_traffic(0, 0);
        test_backpressure();

        req_if.valid <= 1'b0;
        while (prb_expected_q.size() != 0) @(posedge i_clk);
        repeat (NSTG + 5) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lvpm_pkg.sv
hw/rtl/lvpm_chan_if.sv
hw/rtl/lvpm_pipe_ctrl.sv
hw/rtl/lte_distributed_vrb_to_prb_map_top.sv
sim/tb.sv
